@@ rtl/mtb_pkg.sv @@
`timescale 1ns / 1ps
// ============================================================================
// mtb_pkg
// Shared types and constants for the timer bank: request and response
// payloads, the command passed from front to back, and back-end state codes.
// ============================================================================

package mtb_pkg;

    // Default number of timers in the bank
    localparam int TIMER_COUNT_DEF = 8;

    // Fixed field widths
    localparam int TICK_W = 32;
    localparam int ID_W   = 3;
    localparam int FUNC_W = 2;

    // Command queue between front and back
    localparam int QUEUE_DEPTH = 2;

    // Response kinds
    localparam logic KIND_ALLOC  = 1'b0;
    localparam logic KIND_EXPIRY = 1'b1;

    // Operation codes carried in the func field
    typedef enum logic [FUNC_W-1:0] {
        OP_TICK    = 2'd0,
        OP_ALLOC   = 2'd1,
        OP_START   = 2'd2,
        OP_PROCESS = 2'd3
    } op_t;

    // Request payload
    typedef struct packed {
        logic [FUNC_W-1:0] func;
        logic [ID_W-1:0]   timer_index;
        logic [TICK_W-1:0] period_ticks;
        logic              repeat_mode;
    } req_t;

    // Response payload
    typedef struct packed {
        logic            reply_kind;
        logic [ID_W-1:0] timer_id;
        logic            alloc_ok;
        logic            last_of_run;
    } rsp_t;

    // Decoded command handed from front to back
    typedef struct packed {
        op_t               op;
        logic              idx_in_range;
        logic [ID_W-1:0]   idx;
        logic [TICK_W-1:0] period;
        logic              cont;
    } cmd_t;

    // Per-timer settings held in memory
    typedef struct packed {
        logic              cont;
        logic [TICK_W-1:0] period;
    } tmr_cfg_t;

    // Back-end sequencer states
    typedef enum logic [1:0] {
        BK_IDLE,
        BK_READ,
        BK_CHECK,
        BK_FLUSH
    } bk_state_t;

    // Back-end status visible to the top level
    typedef struct packed {
        bk_state_t state;
        logic      pend_valid;
    } bk_stat_t;

endpackage

@@ rtl/mtb_front.sv @@
`timescale 1ns / 1ps
// ============================================================================
// mtb_front
// Accepts requests, decodes the operation and range-checks the timer index,
// and buffers the decoded commands in a short queue for the back end.
// ============================================================================

module mtb_front #(
    parameter int TIMER_COUNT = mtb_pkg::TIMER_COUNT_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  mtb_pkg::req_t  req_data,
    output logic           cmd_valid,
    output mtb_pkg::cmd_t  cmd,
    input  logic           cmd_pop
);

    localparam int PW = (mtb_pkg::QUEUE_DEPTH > 1) ? $clog2(mtb_pkg::QUEUE_DEPTH) : 1;
    localparam int NW = $clog2(mtb_pkg::QUEUE_DEPTH + 1);
    localparam logic [PW-1:0] LAST_SLOT = PW'(mtb_pkg::QUEUE_DEPTH - 1);
    localparam logic [NW-1:0] FULL_CNT  = NW'(mtb_pkg::QUEUE_DEPTH);

    mtb_pkg::cmd_t  q_mem [mtb_pkg::QUEUE_DEPTH];
    mtb_pkg::cmd_t  dec_cmd;
    logic [PW-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [NW-1:0]  count_reg, count_next;
    logic           push;

    // Decode the incoming request
    always_comb
    begin
        dec_cmd.op           = mtb_pkg::op_t'(req_data.func);
        dec_cmd.idx_in_range = (32'(req_data.timer_index) < 32'(TIMER_COUNT));
        dec_cmd.idx          = req_data.timer_index;
        dec_cmd.period       = req_data.period_ticks;
        dec_cmd.cont         = req_data.repeat_mode;
    end

    assign req_ready = (count_reg != FULL_CNT);
    assign push      = req_valid && req_ready;
    assign cmd_valid = (count_reg != '0);
    assign cmd       = q_mem[rd_ptr_reg];

    // Queue pointers and fill count
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST_SLOT) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (cmd_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST_SLOT) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !cmd_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && cmd_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_mem[wr_ptr_reg] <= dec_cmd;
        end
    end

endmodule

@@ rtl/mtb_back.sv @@
`timescale 1ns / 1ps
// ============================================================================
// mtb_back
// Executes decoded commands: tick count, allocation, timer start, and the
// expiry scan, which walks the timer memories one entry at a time and
// drives the response register.
// ============================================================================

module mtb_back #(
    parameter int TIMER_COUNT = mtb_pkg::TIMER_COUNT_DEF
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cmd_valid,
    input  mtb_pkg::cmd_t     cmd,
    output logic              cmd_pop,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output mtb_pkg::rsp_t     rsp_data,
    output mtb_pkg::bk_stat_t stat
);

    localparam int IW = (TIMER_COUNT > 1) ? $clog2(TIMER_COUNT) : 1;
    localparam int CW = $clog2(TIMER_COUNT + 1);
    localparam int XW = (CW > mtb_pkg::ID_W) ? CW : mtb_pkg::ID_W;
    localparam logic [CW-1:0] FULL_COUNT = CW'(TIMER_COUNT);

    // Timer memories
    logic [mtb_pkg::TICK_W-1:0] stamp_mem [TIMER_COUNT];
    mtb_pkg::tmr_cfg_t          cfg_mem   [TIMER_COUNT];
    logic [mtb_pkg::TICK_W-1:0] stamp_rd_reg;
    mtb_pkg::tmr_cfg_t          cfg_rd_reg;

    mtb_pkg::bk_state_t         state_reg, state_next;
    logic [mtb_pkg::TICK_W-1:0] now_reg, now_next;
    logic [CW-1:0]              used_reg, used_next;
    logic [CW-1:0]              scan_reg, scan_next;
    logic [TIMER_COUNT-1:0]     running_reg, running_next;
    logic                       pend_valid_reg, pend_valid_next;
    logic [mtb_pkg::ID_W-1:0]   pend_id_reg, pend_id_next;
    logic                       rsp_valid_reg, rsp_valid_next;
    mtb_pkg::rsp_t              rsp_data_reg, rsp_data_next;

    logic                       stamp_we;
    logic [IW-1:0]              stamp_waddr;
    logic [mtb_pkg::TICK_W-1:0] stamp_wdata;
    logic                       cfg_we;
    mtb_pkg::tmr_cfg_t          cfg_wdata;
    logic                       rd_en;

    logic [XW-1:0]              cmd_idx_x;
    logic [XW-1:0]              used_x;
    logic [XW-1:0]              scan_x;
    logic [IW-1:0]              cmd_idx;
    logic [IW-1:0]              scan_idx;
    logic                       start_ok;
    logic                       out_free;
    logic [mtb_pkg::TICK_W-1:0] elapsed;
    logic                       expired;

    assign cmd_idx_x = XW'(cmd.idx);
    assign used_x    = XW'(used_reg);
    assign scan_x    = XW'(scan_reg);
    assign cmd_idx   = cmd_idx_x[IW-1:0];
    assign scan_idx  = scan_x[IW-1:0];
    assign start_ok  = cmd.idx_in_range && (cmd_idx_x < used_x);
    assign out_free  = !rsp_valid_reg || rsp_ready;

    // Modular elapsed time against the stored period
    assign elapsed = now_reg - stamp_rd_reg;
    assign expired = (elapsed >= cfg_rd_reg.period);

    assign rsp_valid       = rsp_valid_reg;
    assign rsp_data        = rsp_data_reg;
    assign stat.state      = state_reg;
    assign stat.pend_valid = pend_valid_reg;

    // Sequencer: next state, memory controls and response loading
    always_comb
    begin
        state_next      = state_reg;
        now_next        = now_reg;
        used_next       = used_reg;
        scan_next       = scan_reg;
        running_next    = running_reg;
        pend_valid_next = pend_valid_reg;
        pend_id_next    = pend_id_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp_ready;
        rsp_data_next   = rsp_data_reg;
        cmd_pop         = 1'b0;
        stamp_we        = 1'b0;
        stamp_waddr     = cmd_idx;
        stamp_wdata     = now_reg;
        cfg_we          = 1'b0;
        cfg_wdata.cont  = cmd.cont;
        cfg_wdata.period = cmd.period;
        rd_en           = 1'b0;

        unique case (state_reg)
            mtb_pkg::BK_IDLE:
            begin
                if (cmd_valid)
                begin
                    unique case (cmd.op)
                        mtb_pkg::OP_TICK:
                        begin
                            now_next = now_reg + 1'b1;
                            cmd_pop  = 1'b1;
                        end
                        mtb_pkg::OP_ALLOC:
                        begin
                            if (out_free)
                            begin
                                cmd_pop                   = 1'b1;
                                rsp_valid_next            = 1'b1;
                                rsp_data_next.reply_kind  = mtb_pkg::KIND_ALLOC;
                                rsp_data_next.last_of_run = 1'b1;
                                if (used_reg == FULL_COUNT)
                                begin
                                    rsp_data_next.timer_id = '0;
                                    rsp_data_next.alloc_ok = 1'b0;
                                end
                                else
                                begin
                                    rsp_data_next.timer_id = used_x[mtb_pkg::ID_W-1:0];
                                    rsp_data_next.alloc_ok = 1'b1;
                                    used_next              = used_reg + 1'b1;
                                end
                            end
                        end
                        mtb_pkg::OP_START:
                        begin
                            cmd_pop = 1'b1;
                            if (start_ok)
                            begin
                                stamp_we              = 1'b1;
                                cfg_we                = 1'b1;
                                running_next[cmd_idx] = 1'b1;
                            end
                        end
                        mtb_pkg::OP_PROCESS:
                        begin
                            cmd_pop         = 1'b1;
                            scan_next       = '0;
                            pend_valid_next = 1'b0;
                            state_next      = mtb_pkg::BK_READ;
                        end
                        default:
                        begin
                            cmd_pop = 1'b0;
                        end
                    endcase
                end
            end

            // Skip stopped timers, fetch running ones
            mtb_pkg::BK_READ:
            begin
                if (scan_reg >= used_reg)
                begin
                    state_next = mtb_pkg::BK_FLUSH;
                end
                else if (running_reg[scan_idx])
                begin
                    rd_en      = 1'b1;
                    state_next = mtb_pkg::BK_CHECK;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            // Compare; a found expiry releases the one held before it
            mtb_pkg::BK_CHECK:
            begin
                if (!expired)
                begin
                    scan_next  = scan_reg + 1'b1;
                    state_next = mtb_pkg::BK_READ;
                end
                else if (!pend_valid_reg || out_free)
                begin
                    if (pend_valid_reg)
                    begin
                        rsp_valid_next            = 1'b1;
                        rsp_data_next.reply_kind  = mtb_pkg::KIND_EXPIRY;
                        rsp_data_next.timer_id    = pend_id_reg;
                        rsp_data_next.alloc_ok    = 1'b0;
                        rsp_data_next.last_of_run = 1'b0;
                    end
                    pend_valid_next = 1'b1;
                    pend_id_next    = scan_x[mtb_pkg::ID_W-1:0];
                    if (cfg_rd_reg.cont)
                    begin
                        stamp_we    = 1'b1;
                        stamp_waddr = scan_idx;
                    end
                    else
                    begin
                        running_next[scan_idx] = 1'b0;
                    end
                    scan_next  = scan_reg + 1'b1;
                    state_next = mtb_pkg::BK_READ;
                end
            end

            // Release the final expiry, marked last
            mtb_pkg::BK_FLUSH:
            begin
                if (!pend_valid_reg)
                begin
                    state_next = mtb_pkg::BK_IDLE;
                end
                else if (out_free)
                begin
                    rsp_valid_next            = 1'b1;
                    rsp_data_next.reply_kind  = mtb_pkg::KIND_EXPIRY;
                    rsp_data_next.timer_id    = pend_id_reg;
                    rsp_data_next.alloc_ok    = 1'b0;
                    rsp_data_next.last_of_run = 1'b1;
                    pend_valid_next           = 1'b0;
                    state_next                = mtb_pkg::BK_IDLE;
                end
            end

            default:
            begin
                state_next = mtb_pkg::BK_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= mtb_pkg::BK_IDLE;
            now_reg        <= '0;
            used_reg       <= '0;
            scan_reg       <= '0;
            running_reg    <= '0;
            pend_valid_reg <= 1'b0;
            rsp_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            now_reg        <= now_next;
            used_reg       <= used_next;
            scan_reg       <= scan_next;
            running_reg    <= running_next;
            pend_valid_reg <= pend_valid_next;
            rsp_valid_reg  <= rsp_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        pend_id_reg  <= pend_id_next;
        rsp_data_reg <= rsp_data_next;
    end

    // Stamp memory: one write port, one registered read port
    always_ff @(posedge clk)
    begin
        if (stamp_we)
        begin
            stamp_mem[stamp_waddr] <= stamp_wdata;
        end
        if (rd_en)
        begin
            stamp_rd_reg <= stamp_mem[scan_idx];
        end
    end

    // Period and mode memory
    always_ff @(posedge clk)
    begin
        if (cfg_we)
        begin
            cfg_mem[cmd_idx] <= cfg_wdata;
        end
        if (rd_en)
        begin
            cfg_rd_reg <= cfg_mem[scan_idx];
        end
    end

endmodule

@@ rtl/multi_timer_bank_core.sv @@
`timescale 1ns / 1ps
// ============================================================================
// multi_timer_bank_core
// Bank of software timers on one wrapping 32-bit tick count: tick, allocate,
// start and expiry-process requests, with one response per allocation and
// per expired timer.
// ============================================================================
//
//  Channel   Signals                          Direction  Payload
//  -------   -------------------------------  ---------  ----------------------
//  request   req_valid / req_ready / req_data  in         func, index, period, mode
//  response  rsp_valid / rsp_ready / rsp_data  out        kind, id, ok, last flag
//
//  Tick, start and allocate execute in the back end once at the head of the
//  two-entry command queue; allocate waits for a free response slot.
//  Process walks the allocated timers, skipping stopped ones and reading running
//  ones through the registered read port of the timer memories; an expiry that
//  releases a held one stalls while the response register is full.
//  Reset clears the tick count, allocation count and running flags; the timer
//  memories need no clearing pass.

module multi_timer_bank_core #(
    parameter int TIMER_COUNT = mtb_pkg::TIMER_COUNT_DEF
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          req_valid,
    output logic          req_ready,
    input  mtb_pkg::req_t req_data,
    output logic          rsp_valid,
    input  logic          rsp_ready,
    output mtb_pkg::rsp_t rsp_data
);

    logic              cmd_valid;
    logic              cmd_pop;
    mtb_pkg::cmd_t     cmd;
    mtb_pkg::bk_stat_t bk_stat;

    // Request decode and command queue
    mtb_front #(
        .TIMER_COUNT (TIMER_COUNT)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop)
    );

    // Timer state, expiry scan and response register
    mtb_back #(
        .TIMER_COUNT (TIMER_COUNT)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd       (cmd),
        .cmd_pop   (cmd_pop),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data),
        .stat      (bk_stat)
    );

`ifndef SYNTHESIS
    // Back end never consumes from an empty queue
    a_pop_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_pop |-> cmd_valid)
        else $error("command popped from empty queue");

    // An allocation reply always closes its run
    a_alloc_last: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.reply_kind == mtb_pkg::KIND_ALLOC) |-> rsp_data.last_of_run)
        else $error("allocation reply not marked last");

    // Expiry notices never carry a grant
    a_expiry_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && rsp_data.reply_kind == mtb_pkg::KIND_EXPIRY) |-> !rsp_data.alloc_ok)
        else $error("expiry notice with alloc_ok set");

    // No expiry is left held once the scan has finished
    a_idle_no_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (bk_stat.state == mtb_pkg::BK_IDLE) |-> !bk_stat.pend_valid)
        else $error("pending expiry lost at end of scan");
`endif

endmodule

@@ sim/testbench.sv @@
`timescale 1ns / 1ps
// ============================================================================
// testbench
// Self-checking bench for the timer bank. It walks a short table of
// requests, then issues random timer arm-tick-process runs mixed with noise
// requests, under four handshake phases. A local model of the tick count,
// the allocation count and the per-timer settings predicts every response.
// ============================================================================

module testbench;

    localparam int NUM_TIMERS   = 8;
    localparam int PHASE_ITEMS  = 18;
    localparam int DRAIN_CYCLES = 40;

    // Directed table row: request plus an optional hand-typed reply
    typedef struct {
        mtb_pkg::req_t req;
        bit            typed;
        mtb_pkg::rsp_t want;
    } dir_row_t;

    logic          clk;
    logic          rst_n;
    logic          req_valid;
    logic          req_ready;
    mtb_pkg::req_t req_data;
    logic          rsp_valid;
    logic          rsp_ready;
    mtb_pkg::rsp_t rsp_data;

    // Timer bank model state
    logic [31:0] tick_now;
    logic [3:0]  alloc_cnt;
    logic        t_run    [NUM_TIMERS];
    logic        t_cont   [NUM_TIMERS];
    logic [31:0] t_stamp  [NUM_TIMERS];
    logic [31:0] t_period [NUM_TIMERS];

    // Replies still owed by the block, oldest first
    mtb_pkg::rsp_t pending_replies [$];
    dir_row_t      dir_tab [$];
    mtb_pkg::rsp_t reply_want;

    int sender_pct;
    int stall_pct;
    int n_req;
    int n_dir;
    int n_rsp;
    int n_expiry;
    int n_refused;
    int n_errors;

    multi_timer_bank_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req_data  (req_data),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp_data  (rsp_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // Apply one request to the model and queue the replies it owes
    function automatic void advance_timers(input mtb_pkg::req_t r);
        mtb_pkg::rsp_t hits [$];
        mtb_pkg::rsp_t one;
        logic [31:0]   elapsed;
        case (mtb_pkg::op_t'(r.func))
            mtb_pkg::OP_TICK:
            begin
                tick_now = tick_now + 32'd1;
            end
            mtb_pkg::OP_ALLOC:
            begin
                one.reply_kind  = mtb_pkg::KIND_ALLOC;
                one.last_of_run = 1'b1;
                if (alloc_cnt >= NUM_TIMERS)
                begin
                    one.timer_id = '0;
                    one.alloc_ok = 1'b0;
                end
                else
                begin
                    one.timer_id = alloc_cnt[2:0];
                    one.alloc_ok = 1'b1;
                    alloc_cnt    = alloc_cnt + 4'd1;
                end
                pending_replies.push_back(one);
            end
            mtb_pkg::OP_START:
            begin
                // an unallocated index is dropped
                if (r.timer_index < alloc_cnt)
                begin
                    t_stamp[r.timer_index]  = tick_now;
                    t_run[r.timer_index]    = 1'b1;
                    t_period[r.timer_index] = r.period_ticks;
                    t_cont[r.timer_index]   = r.repeat_mode;
                end
            end
            default:
            begin
                // scan allocated timers in index order
                for (int i = 0; i < alloc_cnt; i++)
                begin
                    elapsed = tick_now - t_stamp[i];
                    if (t_run[i] && elapsed >= t_period[i])
                    begin
                        if (t_cont[i])
                            t_stamp[i] = tick_now;
                        else
                            t_run[i] = 1'b0;
                        one.reply_kind  = mtb_pkg::KIND_EXPIRY;
                        one.timer_id    = i[2:0];
                        one.alloc_ok    = 1'b0;
                        one.last_of_run = 1'b0;
                        hits.push_back(one);
                    end
                end
                if (hits.size() > 0)
                    hits[hits.size()-1].last_of_run = 1'b1;
                foreach (hits[k])
                    pending_replies.push_back(hits[k]);
            end
        endcase
    endfunction

    function automatic mtb_pkg::req_t mk_req(input mtb_pkg::op_t op,
                                             input logic [2:0] idx,
                                             input logic [31:0] per,
                                             input logic mode);
        mtb_pkg::req_t r;
        r.func         = op;
        r.timer_index  = idx;
        r.period_ticks = per;
        r.repeat_mode  = mode;
        return r;
    endfunction

    function automatic void add_row(input mtb_pkg::req_t r, input bit typed,
                                    input logic ok, input logic [2:0] id);
        dir_row_t row;
        row.req              = r;
        row.typed            = typed;
        row.want.reply_kind  = mtb_pkg::KIND_ALLOC;
        row.want.timer_id    = id;
        row.want.alloc_ok    = ok;
        row.want.last_of_run = 1'b1;
        dir_tab.push_back(row);
    endfunction

    // Mostly short periods so timers fire, sometimes wide or extreme values
    function automatic logic [31:0] pick_period();
        case ($urandom_range(9))
            0:       return $urandom;
            1:       return 32'hFFFF_FFFF;
            2:       return {1'b1, 31'($urandom)};
            default: return 32'($urandom_range(0, 4));
        endcase
    endfunction

    function automatic mtb_pkg::req_t noise_req();
        return mk_req(mtb_pkg::op_t'($urandom_range(3)), 3'($urandom_range(7)),
                      pick_period(), 1'($urandom_range(1)));
    endfunction

    function automatic void chk_field(input string name, input int want,
                                      input int got);
        if (want != got)
        begin
            $display("%0t: %s mismatch, expected %0d, actual %0d",
                     $time, name, want, got);
            n_errors++;
        end
    endfunction

    // Drive one request at the falling edge and hold it until accepted
    task automatic send_req(input mtb_pkg::req_t r);
        int gap;
        gap = 0;
        while ($urandom_range(99) < sender_pct)
            gap++;
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req_data  <= r;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        advance_timers(r);
        n_req++;
    endtask

    task automatic drop_valid();
        @(negedge clk);
        req_valid <= 1'b0;
    endtask

    // Random part: arm-tick-process runs with random content, plus noise
    task automatic run_random(input int count);
        int sent;
        int arms;
        int ticks;
        bit all_zero;
        sent = 0;
        while (sent < count)
        begin
            if ($urandom_range(99) < 65)
            begin
                all_zero = ($urandom_range(7) == 0);
                arms     = all_zero ? NUM_TIMERS : $urandom_range(1, 4);
                for (int i = 0; i < arms; i++)
                begin
                    send_req(mk_req(mtb_pkg::OP_START,
                                    all_zero ? 3'(i) : 3'($urandom_range(7)),
                                    all_zero ? 32'd0 : pick_period(),
                                    1'($urandom_range(1))));
                    sent++;
                end
                ticks = $urandom_range(0, 4);
                repeat (ticks)
                begin
                    send_req(mk_req(mtb_pkg::OP_TICK, 3'($urandom_range(7)), $urandom,
                                    1'($urandom_range(1))));
                    sent++;
                end
                send_req(mk_req(mtb_pkg::OP_PROCESS, 3'($urandom_range(7)), $urandom,
                                1'($urandom_range(1))));
                sent++;
            end
            else
            begin
                send_req(noise_req());
                sent++;
            end
        end
    endtask

    // Response ready, toggled at the falling edge
    always @(negedge clk)
    begin
        rsp_ready <= ($urandom_range(99) >= stall_pct);
    end

    // Compare each accepted response with the oldest owed reply
    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            n_rsp++;
            if (rsp_data.reply_kind == mtb_pkg::KIND_EXPIRY)
                n_expiry++;
            else if (!rsp_data.alloc_ok)
                n_refused++;
            if (pending_replies.size() == 0)
            begin
                $display("%0t: unexpected response, expected none, actual %h",
                         $time, rsp_data);
                n_errors++;
            end
            else
            begin
                reply_want = pending_replies.pop_front();
                chk_field("reply_kind", int'(reply_want.reply_kind),
                          int'(rsp_data.reply_kind));
                chk_field("timer_id", int'(reply_want.timer_id),
                          int'(rsp_data.timer_id));
                chk_field("alloc_ok", int'(reply_want.alloc_ok),
                          int'(rsp_data.alloc_ok));
                chk_field("last_of_run", int'(reply_want.last_of_run),
                          int'(rsp_data.last_of_run));
            end
        end
    end

    // Hard limit on run time
    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    // Main sequence
    initial
    begin
        int snd_tab [4];
        int stl_tab [4];
        snd_tab = '{0, 65, 0, 9};
        stl_tab = '{0, 0, 65, 9};
        rst_n      = 1'b0;
        req_valid  = 1'b0;
        req_data   = '0;
        rsp_ready  = 1'b0;
        sender_pct = 0;
        stall_pct  = 0;
        n_req      = 0;
        n_rsp      = 0;
        n_expiry   = 0;
        n_refused  = 0;
        n_errors   = 0;
        tick_now   = '0;
        alloc_cnt  = '0;
        for (int i = 0; i < NUM_TIMERS; i++)
        begin
            t_run[i]    = 1'b0;
            t_cont[i]   = 1'b0;
            t_stamp[i]  = '0;
            t_period[i] = '0;
        end

        // Directed rows: empty bank, unallocated starts, full allocation,
        // refusal, zero and maximum periods, restart of a running timer
        add_row(mk_req(mtb_pkg::OP_PROCESS, 3'd0, 32'd0, 1'b0), 0, 1'b0, 3'd0);
        add_row(mk_req(mtb_pkg::OP_START, 3'd0, 32'd0, 1'b0), 0, 1'b0, 3'd0);
        add_row(mk_req(mtb_pkg::OP_ALLOC, 3'd7, 32'hFFFF_FFFF, 1'b1), 1, 1'b1, 3'd0);
        add_row(mk_req(mtb_pkg::OP_ALLOC, 3'd0, 32'd0, 1'b0), 1, 1'b1, 3'd1);
        add_row(mk_req(mtb_pkg::OP_START, 3'd3, 32'd0, 1'b1), 0, 1'b0, 3'd0);
        add_row(mk_req(mtb_pkg::OP_PROCESS, 3'd7, 32'hFFFF_FFFF, 1'b1), 0, 1'b0, 3'd0);
        for (int i = 2; i < NUM_TIMERS; i++)
            add_row(mk_req(mtb_pkg::OP_ALLOC, 3'(i), 32'd0, 1'b0), 1, 1'b1, 3'(i));
        add_row(mk_req(mtb_pkg::OP_ALLOC, 3'd5, 32'd0, 1'b0), 1, 1'b0, 3'd0);
        add_row(mk_req(mtb_pkg::OP_START, 3'd0, 32'd0, 1'b0), 0, 1'b0, 3'd0);
        add_row(mk_req(mtb_pkg::OP_START, 3'd1, 32'd0, 1'b1), 0, 1'b0, 3'd0);
        add_row(mk_req(mtb_pkg::OP_START, 3'd7, 32'hFFFF_FFFF, 1'b1), 0, 1'b0, 3'd0);
        add_row(mk_req(mtb_pkg::OP_START, 3'd2, 32'd2, 1'b0), 0, 1'b0, 3'd0);
        add_row(mk_req(mtb_pkg::OP_PROCESS, 3'd0, 32'd0, 1'b0), 0, 1'b0, 3'd0);
        add_row(mk_req(mtb_pkg::OP_TICK, 3'd0, 32'd0, 1'b0), 0, 1'b0, 3'd0);
        add_row(mk_req(mtb_pkg::OP_TICK, 3'd7, 32'hFFFF_FFFF, 1'b1), 0, 1'b0, 3'd0);
        add_row(mk_req(mtb_pkg::OP_START, 3'd1, 32'd5, 1'b1), 0, 1'b0, 3'd0);
        add_row(mk_req(mtb_pkg::OP_PROCESS, 3'd0, 32'd0, 1'b0), 0, 1'b0, 3'd0);
        n_dir = dir_tab.size();

        repeat (7) @(negedge clk);
        rst_n <= 1'b1;

        // Directed part, no idling
        foreach (dir_tab[k])
        begin
            send_req(dir_tab[k].req);
            if (dir_tab[k].typed)
            begin
                void'(pending_replies.pop_back());
                pending_replies.push_back(dir_tab[k].want);
            end
        end

        // Random part, one handshake phase at a time; the sender holds off
        // between phases until every owed reply has arrived
        for (int p = 0; p < 4; p++)
        begin
            drop_valid();
            while (pending_replies.size() != 0)
                @(posedge clk);
            sender_pct = snd_tab[p];
            stall_pct  = stl_tab[p];
            run_random(PHASE_ITEMS);
        end
        drop_valid();

        while (pending_replies.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("Sent %0d requests (%0d from the table), got %0d responses:",
                 n_req, n_dir, n_rsp);
        $display("  %0d expiries, %0d refused allocations, %0d mismatches.",
                 n_expiry, n_refused, n_errors);
        if (n_errors == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
